// ----- hdl/sfcw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfcw_pkg
// Shared constants, types and helper functions of the substring finder.
// ----------------------------------------------------------------------------
package sfcw_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_TEXT    = 65536;
    localparam int WIN_DEPTH   = MAX_PATTERN + 2;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int SEEN_W      = $clog2(MAX_TEXT + 1);
    localparam int POS_W       = 16;
    localparam int LEN_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int PATTERN_W   = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_CASE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_WORD     = 2'd3;

    localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5f;
    localparam logic [BYTE_W-1:0] CASE_OFFSET     = 8'h20;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern_bytes;
        logic [LEN_W-1:0]     pattern_length;
        logic                 match_case;
        logic                 match_word;
    } t_cfg;

    typedef struct packed {
        logic             hit_prev;
        logic [POS_W-1:0] pos_prev;
        logic             hit_last;
        logic [POS_W-1:0] pos_last;
        logic             last;
    } t_cand;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        if (c inside {[8'h41:8'h5a]}) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
        return (c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]}) ||
               (c == CHAR_UNDERSCORE);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/sfcw_text_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfcw_text_if
// Text byte channel: one word is one byte of text plus its last mark.
// ----------------------------------------------------------------------------
interface sfcw_text_if;
    logic                        valid;
    logic                        ready;
    logic [sfcw_pkg::BYTE_W-1:0] text_byte;
    logic                        last_byte;

    modport source(output valid, output text_byte, output last_byte, input ready);
    modport sink(input valid, input text_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/sfcw_result_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfcw_result_if
// Result channel: one word per text, found flag and match offset.
// ----------------------------------------------------------------------------
interface sfcw_result_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [sfcw_pkg::POS_W-1:0] match_offset;

    modport source(output valid, output found, output match_offset, input ready);
    modport sink(input valid, input found, input match_offset, output ready);
endinterface
`default_nettype wire

// ----- hdl/sfcw_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfcw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sfcw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sfcw_pkg::CFG_IDX_W-1:0] index;
    logic [sfcw_pkg::PATTERN_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/sfcw_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfcw_front
// Accepts text bytes, keeps the byte window and count, and tests both
// candidate match positions in parallel for every byte.
// ----------------------------------------------------------------------------
module sfcw_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    sfcw_text_if.sink                  i_text,
    input  wire sfcw_pkg::t_cfg        i_cfg,
    input  wire logic                  i_q_ready,
    output logic                       o_q_valid,
    output sfcw_pkg::t_cand            o_q_cand
);

    logic [sfcw_pkg::BYTE_W-1:0] r_win [sfcw_pkg::WIN_DEPTH];
    logic [sfcw_pkg::BYTE_W-1:0] n_win [sfcw_pkg::WIN_DEPTH];
    logic [sfcw_pkg::SEEN_W-1:0] r_seen;
    logic [sfcw_pkg::SEEN_W-1:0] n_seen;

    logic                          accept;
    logic [sfcw_pkg::LEN_W-1:0]    len;
    logic [sfcw_pkg::SEEN_W-1:0]   len_x;
    logic                          track;
    logic                          eq_prev;
    logic                          eq_last;
    logic [sfcw_pkg::BYTE_W-1:0]   p_k;
    logic [sfcw_pkg::BYTE_W-1:0]   t_prev;
    logic [sfcw_pkg::BYTE_W-1:0]   t_last;
    logic [sfcw_pkg::LEN_W-1:0]    k4;
    logic [sfcw_pkg::WIN_IDX_W-1:0] idx_prev;
    logic [sfcw_pkg::WIN_IDX_W-1:0] idx_last;
    logic [sfcw_pkg::WIN_IDX_W-1:0] idx_before_prev;
    logic [sfcw_pkg::WIN_IDX_W-1:0] idx_before_last;
    logic                          word_ok_prev;
    logic                          word_ok_last;
    logic [sfcw_pkg::SEEN_W-1:0]   pos_prev_x;
    logic [sfcw_pkg::SEEN_W-1:0]   pos_last_x;

    assign accept       = i_text.valid && i_text.ready;
    assign i_text.ready = i_q_ready;

    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            len = sfcw_pkg::LEN_W'(1);
        end else if (i_cfg.pattern_length > sfcw_pkg::LEN_W'(sfcw_pkg::MAX_PATTERN)) begin
            len = sfcw_pkg::LEN_W'(sfcw_pkg::MAX_PATTERN);
        end else begin
            len = i_cfg.pattern_length;
        end
    end

    assign len_x = sfcw_pkg::SEEN_W'(len);
    assign track = r_seen < sfcw_pkg::SEEN_W'(sfcw_pkg::MAX_TEXT);

    always_comb begin
        n_win[0] = i_text.text_byte;
        for (int j = 1; j < sfcw_pkg::WIN_DEPTH; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    always_comb begin
        eq_prev = 1'b1;
        eq_last = 1'b1;
        for (int k = 0; k < sfcw_pkg::MAX_PATTERN; k++) begin
            k4       = sfcw_pkg::LEN_W'(k);
            p_k      = i_cfg.pattern_bytes[k*sfcw_pkg::BYTE_W +: sfcw_pkg::BYTE_W];
            idx_prev = (k4 < len) ? sfcw_pkg::WIN_IDX_W'(len - k4) : '0;
            idx_last = (k4 < len) ? sfcw_pkg::WIN_IDX_W'(len - k4 - 1'b1) : '0;
            t_prev   = n_win[idx_prev];
            t_last   = n_win[idx_last];
            if (!i_cfg.match_case) begin
                p_k    = sfcw_pkg::fold_case(p_k);
                t_prev = sfcw_pkg::fold_case(t_prev);
                t_last = sfcw_pkg::fold_case(t_last);
            end
            if (k4 < len) begin
                if (p_k != t_prev) eq_prev = 1'b0;
                if (p_k != t_last) eq_last = 1'b0;
            end
        end
    end

    assign idx_before_prev = sfcw_pkg::WIN_IDX_W'(len) + 1'b1;
    assign idx_before_last = sfcw_pkg::WIN_IDX_W'(len);

    assign word_ok_prev = !i_cfg.match_word ||
                          (!sfcw_pkg::is_word_char(i_text.text_byte) &&
                           (!(r_seen >= len_x + 1'b1) ||
                            !sfcw_pkg::is_word_char(n_win[idx_before_prev])));
    assign word_ok_last = !i_cfg.match_word ||
                          !(r_seen >= len_x) ||
                          !sfcw_pkg::is_word_char(n_win[idx_before_last]);

    assign pos_prev_x = r_seen - len_x;
    assign pos_last_x = r_seen + 1'b1 - len_x;

    always_comb begin
        o_q_valid          = accept;
        o_q_cand.hit_prev  = track && (r_seen >= len_x) && eq_prev && word_ok_prev;
        o_q_cand.pos_prev  = pos_prev_x[sfcw_pkg::POS_W-1:0];
        o_q_cand.hit_last  = i_text.last_byte && track && (r_seen + 1'b1 >= len_x) &&
                             eq_last && word_ok_last;
        o_q_cand.pos_last  = pos_last_x[sfcw_pkg::POS_W-1:0];
        o_q_cand.last      = i_text.last_byte;
    end

    always_comb begin
        n_seen = r_seen;
        if (accept) begin
            if (i_text.last_byte) begin
                n_seen = '0;
            end else if (track) begin
                n_seen = r_seen + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/sfcw_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfcw_queue
// Short queue of candidate words between front and back.
// ----------------------------------------------------------------------------
module sfcw_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_valid,
    input  wire sfcw_pkg::t_cand  i_wr_cand,
    output logic                  o_wr_ready,
    output logic                  o_rd_valid,
    output sfcw_pkg::t_cand       o_rd_cand,
    input  wire logic             i_rd_pop
);

    sfcw_pkg::t_cand                r_mem [sfcw_pkg::QUEUE_DEPTH];
    logic [sfcw_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [sfcw_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [sfcw_pkg::QCNT_W-1:0]    r_count;
    logic                           push;
    logic                           pop;

    assign o_wr_ready = r_count != sfcw_pkg::QCNT_W'(sfcw_pkg::QUEUE_DEPTH);
    assign o_rd_valid = r_count != '0;
    assign o_rd_cand  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_cand;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/sfcw_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfcw_back
// Keeps the first qualifying match of the text and delivers the result
// word on the last byte through an output register.
// ----------------------------------------------------------------------------
module sfcw_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire sfcw_pkg::t_cand  i_q_cand,
    output logic                  o_q_pop,
    sfcw_result_if.source         o_res
);

    logic                       r_match;
    logic [sfcw_pkg::POS_W-1:0] r_pos;
    logic                       r_out_valid;
    logic                       r_found;
    logic [sfcw_pkg::POS_W-1:0] r_offset;
    logic                       n_found;
    logic [sfcw_pkg::POS_W-1:0] n_pos;

    assign o_q_pop = i_q_valid && (!i_q_cand.last || !r_out_valid || o_res.ready);

    always_comb begin
        n_found = r_match || i_q_cand.hit_prev || i_q_cand.hit_last;
        if (r_match) begin
            n_pos = r_pos;
        end else if (i_q_cand.hit_prev) begin
            n_pos = i_q_cand.pos_prev;
        end else begin
            n_pos = i_q_cand.pos_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_match <= i_q_cand.last ? 1'b0 : n_found;
            end
            if (o_q_pop && i_q_cand.last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pos <= n_pos;
            if (i_q_cand.last) begin
                r_found  <= n_found;
                r_offset <= n_found ? n_pos : '0;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.found        = r_found;
    assign o_res.match_offset = r_offset;

endmodule
`default_nettype wire

// ----- hdl/substring_find_case_word.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// substring_find_case_word
// Substring search over a byte stream with optional case folding and
// whole-word matching; one result word per text.
// Throughput: one text byte per cycle while the candidate queue has room.
// Result path: candidate queue, then the back-end result output register.
// Reset: synchronous; restores default configuration, clears text state
// and the candidate queue.
// ----------------------------------------------------------------------------
module substring_find_case_word (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    sfcw_text_if.sink       i_text,
    sfcw_cfg_if.sink        i_cfg,
    sfcw_result_if.source   o_res
);

    sfcw_pkg::t_cfg  r_cfg;
    logic            q_wr_valid;
    sfcw_pkg::t_cand q_wr_cand;
    logic            q_wr_ready;
    logic            q_rd_valid;
    sfcw_pkg::t_cand q_rd_cand;
    logic            q_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes  <= '0;
            r_cfg.pattern_length <= sfcw_pkg::LEN_W'(1);
            r_cfg.match_case     <= 1'b0;
            r_cfg.match_word     <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                sfcw_pkg::REG_PATTERN_BYTES:  r_cfg.pattern_bytes  <= i_cfg.data;
                sfcw_pkg::REG_PATTERN_LENGTH: r_cfg.pattern_length <=
                                                  i_cfg.data[sfcw_pkg::LEN_W-1:0];
                sfcw_pkg::REG_MATCH_CASE:     r_cfg.match_case     <= i_cfg.data[0];
                sfcw_pkg::REG_MATCH_WORD:     r_cfg.match_word     <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    sfcw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_text    (i_text),
        .i_cfg     (r_cfg),
        .i_q_ready (q_wr_ready),
        .o_q_valid (q_wr_valid),
        .o_q_cand  (q_wr_cand)
    );

    sfcw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (q_wr_valid),
        .i_wr_cand  (q_wr_cand),
        .o_wr_ready (q_wr_ready),
        .o_rd_valid (q_rd_valid),
        .o_rd_cand  (q_rd_cand),
        .i_rd_pop   (q_pop)
    );

    sfcw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_rd_valid),
        .i_q_cand  (q_rd_cand),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire
